### sv/axis_reduce_int8_requant_macros.svh
// Assertion helpers for the reduction block checker.
// Every macro samples on clk of the scope that uses it.
`ifndef AXIS_REDUCE_INT8_REQUANT_MACROS_SVH
`define AXIS_REDUCE_INT8_REQUANT_MACROS_SVH

// Next-cycle check that also runs while reset is asserted.
`define ARQ_ASSERT_NEXT(lbl, cond, expr) \
  lbl: assert property (@(posedge clk) (cond) |=> (expr)) \
    else $error("arq: next-cycle check failed");

// Same-cycle check, off during reset.
`define ARQ_ASSERT_NOW(lbl, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("arq: same-cycle check failed");

// Next-cycle check, off during reset.
`define ARQ_ASSERT_NEXT_RUN(lbl, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("arq: next-cycle check failed");

`endif

### sv/arq_pkg.sv
package arq_pkg;

  localparam int unsigned VAL_W      = 8;
  localparam int unsigned ACC_W      = 24;
  localparam int unsigned IDX_OUT_W  = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 31;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_REDUCE_OP        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_LEN         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_LEN        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_MULTIPLIER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_SHIFT      = 3'd4;

  typedef enum logic [1:0] {
    OP_SUM  = 2'd0,
    OP_MEAN = 2'd1,
    OP_MAX  = 2'd2,
    OP_MIN  = 2'd3
  } reduce_op_t;

  // Sideband that travels with each request down the pipeline
  typedef struct packed {
    logic                 has_result;
    logic [IDX_OUT_W-1:0] inner_index;
    logic                 group_end;
  } tag_t;

endpackage

### sv/arq_accum.sv
module arq_accum #(
  parameter int unsigned INNER_MAX = 256,
  parameter int unsigned AXIS_MAX  = 65535
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_accept,
  input  logic signed [arq_pkg::VAL_W-1:0] in_value,
  input  arq_pkg::reduce_op_t             reduce_op,
  input  logic [15:0]                     axis_len,
  input  logic [8:0]                      inner_len,
  output logic signed [arq_pkg::ACC_W-1:0] acc_o,
  output arq_pkg::tag_t                   tag_o
);

  localparam int unsigned IDX_W = (INNER_MAX > 1) ? $clog2(INNER_MAX) : 1;
  localparam int unsigned AX_W  = (AXIS_MAX > 1) ? $clog2(AXIS_MAX) : 1;
  localparam int unsigned IC_W  = ((IDX_W > 9) ? IDX_W : 9) + 1;
  localparam int unsigned AC_W  = 17;
  localparam int unsigned ACC_W = arq_pkg::ACC_W;

  logic [IDX_W-1:0] inner_pos_r;
  logic [AX_W-1:0]  axis_pos_r;
  logic [IC_W-1:0]  eff_inner;
  logic [AC_W-1:0]  eff_axis;
  logic             last_inner;
  logic             last_axis;

  logic                            r_valid_r;
  logic signed [arq_pkg::VAL_W-1:0] r_value_r;
  logic [IDX_W-1:0]                r_idx_r;
  logic                            r_first_r;
  arq_pkg::tag_t                   r_tag_r;
  logic                            fwd_r;
  logic [ACC_W-1:0]                rd_r;

  logic [ACC_W-1:0] acc_mem [INNER_MAX];

  logic signed [ACC_W-1:0] acc2_r;
  logic signed [ACC_W-1:0] acc2_nxt;
  arq_pkg::tag_t           tag2_r;

  logic signed [ACC_W-1:0] old_acc;
  logic signed [ACC_W-1:0] val_ext;
  logic signed [ACC_W:0]   sum;

  always_comb begin
    eff_inner = (inner_len == 9'd0) ? IC_W'(1) : IC_W'(inner_len);
    if (eff_inner > IC_W'(INNER_MAX)) begin
      eff_inner = IC_W'(INNER_MAX);
    end
    eff_axis = (axis_len == 16'd0) ? AC_W'(1) : AC_W'(axis_len);
    if (eff_axis > AC_W'(AXIS_MAX)) begin
      eff_axis = AC_W'(AXIS_MAX);
    end
  end

  assign last_inner = (IC_W'(inner_pos_r) + IC_W'(1)) >= eff_inner;
  assign last_axis  = (AC_W'(axis_pos_r) + AC_W'(1)) >= eff_axis;

  // Position counters and the request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_pos_r <= '0;
      axis_pos_r  <= '0;
      r_valid_r   <= 1'b0;
      fwd_r       <= 1'b0;
    end else if (en) begin
      r_valid_r <= in_accept;
      if (in_accept) begin
        fwd_r <= r_valid_r && (r_idx_r == inner_pos_r);
        if (last_inner) begin
          inner_pos_r <= '0;
          axis_pos_r  <= last_axis ? '0 : axis_pos_r + AX_W'(1);
        end else begin
          inner_pos_r <= inner_pos_r + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      r_value_r <= in_value;
      r_idx_r   <= inner_pos_r;
      r_first_r <= (axis_pos_r == '0);
      r_tag_r   <= '{has_result:  last_axis,
                     inner_index: arq_pkg::IDX_OUT_W'(inner_pos_r),
                     group_end:   last_inner};
    end
  end

  // Accumulator store: read at accept, written back from the request register
  always_ff @(posedge clk) begin
    if (in_accept) begin
      rd_r <= acc_mem[inner_pos_r];
    end
  end

  always_ff @(posedge clk) begin
    if (en && r_valid_r) begin
      acc_mem[r_idx_r] <= acc2_nxt;
    end
  end

  // Bypass the write that lands on the same edge as this request's read
  assign old_acc = fwd_r ? acc2_r : $signed(rd_r);
  assign val_ext = {{(ACC_W - arq_pkg::VAL_W){r_value_r[arq_pkg::VAL_W-1]}}, r_value_r};
  assign sum     = {old_acc[ACC_W-1], old_acc} + {val_ext[ACC_W-1], val_ext};

  always_comb begin
    acc2_nxt = old_acc;
    if (r_first_r) begin
      acc2_nxt = val_ext;
    end else begin
      case (reduce_op)
        arq_pkg::OP_SUM, arq_pkg::OP_MEAN: begin
          if (sum[ACC_W] != sum[ACC_W-1]) begin
            acc2_nxt = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
          end else begin
            acc2_nxt = sum[ACC_W-1:0];
          end
        end
        arq_pkg::OP_MAX: acc2_nxt = (val_ext > old_acc) ? val_ext : old_acc;
        arq_pkg::OP_MIN: acc2_nxt = (val_ext < old_acc) ? val_ext : old_acc;
        default:         acc2_nxt = old_acc;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag2_r <= '0;
    end else if (en) begin
      tag2_r <= '{has_result:  r_valid_r && r_tag_r.has_result,
                  inner_index: r_tag_r.inner_index,
                  group_end:   r_tag_r.group_end};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc2_r <= acc2_nxt;
    end
  end

  assign acc_o = acc2_r;
  assign tag_o = tag2_r;

endmodule

### sv/arq_requant.sv
module arq_requant (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic signed [arq_pkg::ACC_W-1:0] acc_i,
  input  arq_pkg::tag_t                    tag_i,
  input  logic [30:0]                      scale_multiplier,
  input  logic [5:0]                       scale_shift,
  output logic signed [arq_pkg::ACC_W-1:0] result_o,
  output arq_pkg::tag_t                    tag_o
);

  localparam int unsigned ACC_W  = arq_pkg::ACC_W;
  localparam int unsigned PROD_W = ACC_W + 32;
  localparam int unsigned EXT_W  = 65;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [ACC_W-1:0]  acc3_r;
  arq_pkg::tag_t            tag3_r;

  logic signed [EXT_W-1:0] ext;
  logic signed [EXT_W-1:0] half;
  logic signed [EXT_W-1:0] shf;
  logic signed [7:0]       sat;
  logic                    active;

  assign prod_nxt = acc_i * $signed({1'b0, scale_multiplier});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag3_r <= '0;
    end else if (en) begin
      tag3_r <= tag_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      acc3_r <= acc_i;
    end
  end

  // Round half up, floor shift, clamp to int8
  always_comb begin
    ext  = {{(EXT_W - PROD_W){prod_r[PROD_W-1]}}, prod_r};
    half = (scale_shift == 6'd0) ? '0 : (EXT_W'(1) <<< (scale_shift - 6'd1));
    shf  = (ext + half) >>> scale_shift;
    if (shf > 65'sd127) begin
      sat = 8'sd127;
    end else if (shf < -65'sd128) begin
      sat = -8'sd128;
    end else begin
      sat = shf[7:0];
    end
  end

  assign active   = (scale_multiplier != 31'd1) || (scale_shift != 6'd0);
  assign result_o = active ? {{(ACC_W - 8){sat[7]}}, sat} : acc3_r;
  assign tag_o    = tag3_r;

endmodule

### sv/axis_reduce_int8_requant.sv
// Axis reduction of an int8 tensor stream with optional requantization.
// in channel: one int8 element per request, in memory order (outer,
//   reduced axis, inner), in_valid/in_stall; one per cycle unless stalled.
// out channel: one request per finished inner position (on the last
//   element along the axis): the reduced value, its inner index and a
//   group_end flag on the last inner position; other elements produce nothing.
// cfg port: write-only, taken on any cycle with cfg_wr_en high. Change
//   registers only while no element is in flight.
// Pipeline: an accepted element passes the request register, accumulate
//   and multiply stages, then round/clamp into the output register.
// Throughput: one element per cycle unless stalled, set by the single read
//   and single write port of the accumulator store; a read that collides
//   with the same-edge write is bypassed from the accumulate stage.
// Reset (synchronous, active low): counters restart at axis 0, inner 0;
//   the pipeline and output empty; registers return to sum, lengths 1,
//   multiplier 1, shift 0. Accumulator contents are not cleared: the
//   first element along the axis loads each entry.
// Back-pressure: a held result stops intake only when another result sits
//   right behind it; then in_stall rises and the whole pipeline holds.
module axis_reduce_int8_requant #(
  parameter int unsigned INNER_MAX = 256,
  parameter int unsigned AXIS_MAX  = 65535
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [7:0]                     in_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [23:0]                    out_result,
  output logic [7:0]                            out_inner_index,
  output logic                                  out_group_end,
  input  logic                                  cfg_wr_en,
  input  logic [arq_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [arq_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  arq_pkg::reduce_op_t reduce_op_r;
  logic [15:0]         axis_len_r;
  logic [8:0]          inner_len_r;
  logic [30:0]         scale_multiplier_r;
  logic [5:0]          scale_shift_r;

  logic                              en;
  logic                              in_accept;
  logic signed [arq_pkg::ACC_W-1:0]  acc;
  arq_pkg::tag_t                     acc_tag;
  logic signed [arq_pkg::ACC_W-1:0]  rq_result;
  arq_pkg::tag_t                     rq_tag;

  logic                              out_valid_r;
  logic signed [arq_pkg::ACC_W-1:0]  out_result_r;
  logic [7:0]                        out_inner_index_r;
  logic                              out_group_end_r;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reduce_op_r        <= arq_pkg::OP_SUM;
      axis_len_r         <= 16'd1;
      inner_len_r        <= 9'd1;
      scale_multiplier_r <= 31'd1;
      scale_shift_r      <= 6'd0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        arq_pkg::CFG_REDUCE_OP:        reduce_op_r <= arq_pkg::reduce_op_t'(cfg_wdata[1:0]);
        arq_pkg::CFG_AXIS_LEN:         axis_len_r <= cfg_wdata[15:0];
        arq_pkg::CFG_INNER_LEN:        inner_len_r <= cfg_wdata[8:0];
        arq_pkg::CFG_SCALE_MULTIPLIER: scale_multiplier_r <= cfg_wdata[30:0];
        arq_pkg::CFG_SCALE_SHIFT:      scale_shift_r <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  // Hold the pipeline only when a result in the last stage has nowhere to go
  assign en        = !(out_valid_r && out_stall && rq_tag.has_result);
  assign in_stall  = !en;
  assign in_accept = in_valid && en;

  arq_accum #(
    .INNER_MAX (INNER_MAX),
    .AXIS_MAX  (AXIS_MAX)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_accept (in_accept),
    .in_value  (in_value),
    .reduce_op (reduce_op_r),
    .axis_len  (axis_len_r),
    .inner_len (inner_len_r),
    .acc_o     (acc),
    .tag_o     (acc_tag)
  );

  arq_requant u_requant (
    .clk              (clk),
    .rst_n            (rst_n),
    .en               (en),
    .acc_i            (acc),
    .tag_i            (acc_tag),
    .scale_multiplier (scale_multiplier_r),
    .scale_shift      (scale_shift_r),
    .result_o         (rq_result),
    .tag_o            (rq_tag)
  );

  // Output register: load a new result, else drop the one just taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en && rq_tag.has_result) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && rq_tag.has_result) begin
      out_result_r      <= rq_result;
      out_inner_index_r <= rq_tag.inner_index;
      out_group_end_r   <= rq_tag.group_end;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result      = out_result_r;
  assign out_inner_index = out_inner_index_r;
  assign out_group_end   = out_group_end_r;

endmodule

### sv/arq_checker.sv
`include "axis_reduce_int8_requant_macros.svh"

module arq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [23:0] out_result
);

  // Reset empties the output
  `ARQ_ASSERT_NEXT(a_reset_clears_out, !rst_n, !out_valid && !in_stall)

  // Intake stalls only behind a held result
  `ARQ_ASSERT_NOW(a_stall_from_backpressure, in_stall, out_valid && out_stall)

  // A held result stays offered
  `ARQ_ASSERT_NEXT_RUN(a_out_held, out_valid && out_stall, out_valid)

  // A held result does not change
  `ARQ_ASSERT_NEXT_RUN(a_out_stable, out_valid && out_stall, $stable(out_result))

endmodule

bind axis_reduce_int8_requant arq_checker u_arq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_result (out_result)
);
